// ===== src/assert_macros.svh =====
// assertion helpers for the resampler
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/tvr_pkg.sv =====
// shared types, constants and helpers of the trilinear volume resampler
// no dependencies
`timescale 1ns / 1ps

package tvr_pkg;

   localparam int VALUE_BITS    = 16;
   localparam int COORD_BITS    = 8;
   localparam int IN_DIM_BITS   = 7;
   localparam int OUT_DIM_BITS  = 9;
   localparam int MAX_IN_DIM    = 64;
   localparam int MAX_OUT_DIM   = 256;
   localparam int IDX_BITS      = 6;
   localparam int ADDR_BITS     = 3 * IDX_BITS;
   localparam int STORE_DEPTH   = MAX_IN_DIM * MAX_IN_DIM * MAX_IN_DIM;
   localparam int FRAC_BITS     = 16;
   localparam int DIV_BITS      = 31;
   localparam int DIV_CNT_BITS  = 5;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 9;

   localparam logic [CSR_IDX_BITS-1:0] REG_IN_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_IN_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_IN_DEPTH   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_OUT_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_OUT_HEIGHT = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_OUT_DEPTH  = 3'd5;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef struct packed {
      logic                          command;
      logic [COORD_BITS-1:0]         pos_x;
      logic [COORD_BITS-1:0]         pos_y;
      logic [COORD_BITS-1:0]         pos_z;
      logic signed [VALUE_BITS-1:0]  voxel_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0]  sample_value;
      logic                          out_of_range;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EXEC, ST_DIV_LOAD, ST_DIV_RUN, ST_MAP, ST_RD, ST_CAP,
      ST_XACC, ST_YMUL, ST_YACC, ST_ZMUL, ST_ZACC, ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      MUL_X, MUL_Y, MUL_Z
   } mul_sel_type;

   typedef struct packed {
      logic         latch_req;
      logic         do_write;
      logic         div_load;
      logic         div_step;
      logic         map_load;
      logic [1:0]   axis;
      logic         rd_en;
      logic [2:0]   corner;
      logic         cap_a;
      logic         mul_en;
      mul_sel_type  mul_sel;
      logic         x_acc;
      logic         y_acc;
      logic         z_acc;
      logic         load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_sample;
      logic out_range;
      logic rsp_busy;
   } ctl_status_type;

   // zero reads as one, larger sizes saturate; only the low IN_DIM_BITS bits are kept
   function automatic logic [IN_DIM_BITS-1:0] sat_in_dim(input logic [CSR_DATA_BITS-1:0] v);
      logic [IN_DIM_BITS-1:0] m;
      m = v[IN_DIM_BITS-1:0];
      if (m == '0) return IN_DIM_BITS'(1);
      if (m > IN_DIM_BITS'(MAX_IN_DIM)) return IN_DIM_BITS'(MAX_IN_DIM);
      return m;
   endfunction

   function automatic logic [OUT_DIM_BITS-1:0] sat_out_dim(input logic [CSR_DATA_BITS-1:0] v);
      logic [OUT_DIM_BITS-1:0] m;
      m = v[OUT_DIM_BITS-1:0];
      if (m == '0) return OUT_DIM_BITS'(1);
      if (m > OUT_DIM_BITS'(MAX_OUT_DIM)) return OUT_DIM_BITS'(MAX_OUT_DIM);
      return m;
   endfunction

endpackage

// ===== src/tvr_ctrl.sv =====
// sequencer of the resampler: division, neighbour reads and blends
// depends on tvr_pkg
`timescale 1ns / 1ps

module tvr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  tvr_pkg::ctl_status_type  status,
   output tvr_pkg::ctl_cmd_type     cmd
);

   tvr_pkg::state_type                 state_ff, state_in;
   logic [1:0]                         axis_ff, axis_in;
   logic [tvr_pkg::DIV_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [2:0]                         corner_ff, corner_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tvr_pkg::ST_IDLE;
         axis_ff   <= '0;
         cnt_ff    <= '0;
         corner_ff <= '0;
      end else begin
         state_ff  <= state_in;
         axis_ff   <= axis_in;
         cnt_ff    <= cnt_in;
         corner_ff <= corner_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      cnt_in     = cnt_ff;
      corner_in  = corner_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.axis   = axis_ff;
      cmd.corner = corner_ff;
      cmd.mul_sel = tvr_pkg::MUL_X;
      case (state_ff)
         tvr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in = tvr_pkg::ST_EXEC;
            end
         end
         tvr_pkg::ST_EXEC: begin
            if (!status.is_sample) begin
               cmd.do_write = 1'b1;
               state_in = tvr_pkg::ST_IDLE;
            end else if (status.out_range) begin
               state_in = tvr_pkg::ST_FIN;
            end else begin
               axis_in = '0;
               state_in = tvr_pkg::ST_DIV_LOAD;
            end
         end
         tvr_pkg::ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            cnt_in = '0;
            state_in = tvr_pkg::ST_DIV_RUN;
         end
         tvr_pkg::ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == tvr_pkg::DIV_CNT_BITS'(tvr_pkg::DIV_BITS - 1)) begin
               state_in = tvr_pkg::ST_MAP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         tvr_pkg::ST_MAP: begin
            cmd.map_load = 1'b1;
            if (axis_ff == 2'd2) begin
               corner_in = '0;
               state_in = tvr_pkg::ST_RD;
            end else begin
               axis_in = axis_ff + 1'b1;
               state_in = tvr_pkg::ST_DIV_LOAD;
            end
         end
         tvr_pkg::ST_RD: begin
            cmd.rd_en = 1'b1;
            state_in = tvr_pkg::ST_CAP;
         end
         tvr_pkg::ST_CAP: begin
            if (!corner_ff[0]) begin
               cmd.cap_a = 1'b1;
               corner_in = corner_ff + 1'b1;
               state_in = tvr_pkg::ST_RD;
            end else begin
               cmd.mul_en = 1'b1;
               cmd.mul_sel = tvr_pkg::MUL_X;
               state_in = tvr_pkg::ST_XACC;
            end
         end
         tvr_pkg::ST_XACC: begin
            cmd.x_acc = 1'b1;
            if (corner_ff[1]) begin
               state_in = tvr_pkg::ST_YMUL;
            end else begin
               corner_in = corner_ff + 1'b1;
               state_in = tvr_pkg::ST_RD;
            end
         end
         tvr_pkg::ST_YMUL: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = tvr_pkg::MUL_Y;
            state_in = tvr_pkg::ST_YACC;
         end
         tvr_pkg::ST_YACC: begin
            cmd.y_acc = 1'b1;
            if (corner_ff == 3'd7) begin
               state_in = tvr_pkg::ST_ZMUL;
            end else begin
               corner_in = corner_ff + 1'b1;
               state_in = tvr_pkg::ST_RD;
            end
         end
         tvr_pkg::ST_ZMUL: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = tvr_pkg::MUL_Z;
            state_in = tvr_pkg::ST_ZACC;
         end
         tvr_pkg::ST_ZACC: begin
            cmd.z_acc = 1'b1;
            state_in = tvr_pkg::ST_FIN;
         end
         tvr_pkg::ST_FIN: begin
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in = tvr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tvr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/tvr_dp.sv =====
// datapath of the resampler: size registers, voxel store, divider, blend unit
// depends on tvr_pkg
`timescale 1ns / 1ps

module tvr_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tvr_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output tvr_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_we,
   input  logic [tvr_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [tvr_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  tvr_pkg::ctl_cmd_type                  cmd,
   output tvr_pkg::ctl_status_type               status
);

   localparam int VB = tvr_pkg::VALUE_BITS;
   localparam int FB = tvr_pkg::FRAC_BITS;
   localparam int IB = tvr_pkg::IDX_BITS;
   localparam int NI = tvr_pkg::IN_DIM_BITS;
   localparam int NO = tvr_pkg::OUT_DIM_BITS;
   localparam int DB = tvr_pkg::DIV_BITS;

   logic [NI-1:0]        in_dim_ff [3];
   logic [NO-1:0]        out_dim_ff [3];
   tvr_pkg::req_type     req_ff;
   logic [VB-1:0]        mem [tvr_pkg::STORE_DEPTH];
   logic [VB-1:0]        rdata_ff;
   logic [DB-1:0]        dvd_ff, dvd_in;
   logic [NO-1:0]        rem_ff, rem_in, dvs_ff;
   logic [IB-1:0]        lo_ff [3];
   logic [IB-1:0]        hi_ff [3];
   logic [FB-1:0]        frac_ff [3];
   logic [VB-1:0]        va_ff;
   logic [31:0]          cxa_ff, cxb_ff, cya_ff, cyb_ff;
   logic signed [49:0]   prod_ff, prod_in;
   logic [VB-1:0]        res_ff, res_in;
   logic                 rsp_valid_ff;
   tvr_pkg::rsp_type     rsp_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            in_dim_ff[i]  <= NI'(1);
            out_dim_ff[i] <= NO'(1);
         end
      end else if (csr_we) begin
         case (csr_index)
            tvr_pkg::REG_IN_WIDTH:   in_dim_ff[0]  <= tvr_pkg::sat_in_dim(csr_wdata);
            tvr_pkg::REG_IN_HEIGHT:  in_dim_ff[1]  <= tvr_pkg::sat_in_dim(csr_wdata);
            tvr_pkg::REG_IN_DEPTH:   in_dim_ff[2]  <= tvr_pkg::sat_in_dim(csr_wdata);
            tvr_pkg::REG_OUT_WIDTH:  out_dim_ff[0] <= tvr_pkg::sat_out_dim(csr_wdata);
            tvr_pkg::REG_OUT_HEIGHT: out_dim_ff[1] <= tvr_pkg::sat_out_dim(csr_wdata);
            tvr_pkg::REG_OUT_DEPTH:  out_dim_ff[2] <= tvr_pkg::sat_out_dim(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) req_ff <= req_data;
   end

   // range checks on the latched transaction
   logic in_grid, out_range;
   assign in_grid = ({1'b0, req_ff.pos_x} < {2'b0, in_dim_ff[0]}) &&
                    ({1'b0, req_ff.pos_y} < {2'b0, in_dim_ff[1]}) &&
                    ({1'b0, req_ff.pos_z} < {2'b0, in_dim_ff[2]});
   assign out_range = ({1'b0, req_ff.pos_x} >= out_dim_ff[0]) ||
                      ({1'b0, req_ff.pos_y} >= out_dim_ff[1]) ||
                      ({1'b0, req_ff.pos_z} >= out_dim_ff[2]);

   // voxel store, z-major layout
   logic [tvr_pkg::ADDR_BITS-1:0] waddr, raddr;
   assign waddr = {req_ff.pos_z[IB-1:0], req_ff.pos_y[IB-1:0], req_ff.pos_x[IB-1:0]};
   assign raddr = {(cmd.corner[2] ? hi_ff[2] : lo_ff[2]),
                   (cmd.corner[1] ? hi_ff[1] : lo_ff[1]),
                   (cmd.corner[0] ? hi_ff[0] : lo_ff[0])};

   always_ff @(posedge clock) begin
      if (cmd.do_write && in_grid) mem[waddr] <= req_ff.voxel_value;
      if (cmd.rd_en) rdata_ff <= mem[raddr];
   end

   // per-axis operands
   logic [7:0]    pos_sel;
   logic [NI-1:0] nin_sel;
   always_comb begin
      case (cmd.axis)
         2'd0: begin pos_sel = req_ff.pos_x; nin_sel = in_dim_ff[0]; end
         2'd1: begin pos_sel = req_ff.pos_y; nin_sel = in_dim_ff[1]; end
         default: begin pos_sel = req_ff.pos_z; nin_sel = in_dim_ff[2]; end
      endcase
   end

   // restoring divider, one quotient bit per cycle
   logic [15:0] num_base;
   logic [NO:0] rem_sh;
   assign num_base = 16'({pos_sel, 1'b1}) * 16'(nin_sel);
   assign rem_sh   = {rem_ff, dvd_ff[DB-1]};

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      if (cmd.div_load) begin
         // (2o+1)*in scaled by half of one in q16
         dvd_in = {1'b0, num_base[14:0], 15'b0};
         rem_in = '0;
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = NO'(rem_sh - {1'b0, dvs_ff});
            dvd_in = {dvd_ff[DB-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[NO-1:0];
            dvd_in = {dvd_ff[DB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      if (cmd.div_load) begin
         case (cmd.axis)
            2'd0: dvs_ff <= out_dim_ff[0];
            2'd1: dvs_ff <= out_dim_ff[1];
            default: dvs_ff <= out_dim_ff[2];
         endcase
      end
   end

   // source coordinate: shift by half a voxel and clamp to the grid
   logic signed [32:0] s_raw;
   logic [21:0]        s_max, s_cl;
   logic [IB:0]        lo_p1;
   assign s_raw = $signed({2'b0, dvd_ff}) - 33'sd32768;
   assign s_max = {6'(nin_sel - 1'b1), 16'b0};
   always_comb begin
      if (s_raw < 0) s_cl = '0;
      else if (s_raw > $signed({11'b0, s_max})) s_cl = s_max;
      else s_cl = s_raw[21:0];
   end
   assign lo_p1 = {1'b0, s_cl[21:16]} + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.map_load) begin
         lo_ff[cmd.axis]   <= s_cl[21:16];
         frac_ff[cmd.axis] <= s_cl[15:0];
         hi_ff[cmd.axis]   <= (lo_p1 < nin_sel) ? lo_p1[IB-1:0] : IB'(nin_sel - 1'b1);
      end
   end

   // shared multiplier: difference of neighbours times weight
   logic signed [32:0] op_a;
   logic signed [16:0] op_b;
   logic        [16:0] dx;
   always_comb begin
      dx = {rdata_ff[VB-1], rdata_ff} - {va_ff[VB-1], va_ff};
      case (cmd.mul_sel)
         tvr_pkg::MUL_X: begin
            op_a = {{16{dx[16]}}, dx};
            op_b = {1'b0, frac_ff[0]};
         end
         tvr_pkg::MUL_Y: begin
            op_a = {cxb_ff[31], cxb_ff} - {cxa_ff[31], cxa_ff};
            op_b = {1'b0, frac_ff[1]};
         end
         tvr_pkg::MUL_Z: begin
            op_a = {cyb_ff[31], cyb_ff} - {cya_ff[31], cya_ff};
            op_b = {1'b0, frac_ff[2]};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
      prod_in = op_a * op_b;
   end

   // accumulate a*one + diff*t, with rounding where the format narrows
   logic [31:0] xsum;
   logic [50:0] ysum, zsum;
   logic signed [18:0] zr;
   assign xsum = {va_ff, 16'b0} + prod_ff[31:0];
   assign ysum = {{3{cxa_ff[31]}}, cxa_ff, 16'b0} + {prod_ff[49], prod_ff} + 51'd32768;
   assign zsum = {{3{cya_ff[31]}}, cya_ff, 16'b0} + {prod_ff[49], prod_ff} + 51'h8000_0000;
   assign zr   = $signed(zsum[50:32]);
   always_comb begin
      if (zr > 19'sd32767) res_in = 16'h7fff;
      else if (zr < -19'sd32768) res_in = 16'h8000;
      else res_in = zr[VB-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_a) va_ff <= rdata_ff;
      if (cmd.mul_en) prod_ff <= prod_in;
      if (cmd.x_acc) begin
         if (cmd.corner[1]) cxb_ff <= xsum;
         else cxa_ff <= xsum;
      end
      if (cmd.y_acc) begin
         if (cmd.corner[2]) cyb_ff <= ysum[47:16];
         else cya_ff <= ysum[47:16];
      end
      if (cmd.z_acc) res_ff <= res_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.sample_value <= out_range ? '0 : res_ff;
         rsp_ff.out_of_range <= out_range;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;
   assign status.is_sample = (req_ff.command == tvr_pkg::CMD_SAMPLE);
   assign status.out_range = out_range;
   assign status.rsp_busy  = rsp_valid_ff && !rsp_ready;

endmodule

// ===== src/trilinear_volume_resampler.sv =====
// Trilinear volume resampler, one transaction at a time. A write transaction
// stores an in-grid voxel in decode. A sample transaction passes through the
// accepting state, a decode state, three divisions (load, 31 quotient bits,
// clamp) on one shared bit-serial divider, then eight single-port reads of the
// 64x64x64 voxel memory interleaved with seven blends on one shared multiplier,
// and a final state that loads the result once the output register is free; an
// out-of-range sample goes from decode to that final state. The voxel memory is
// not cleared: reading a voxel never written gives an arbitrary value.
// depends on tvr_pkg, tvr_ctrl, tvr_dp and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module trilinear_volume_resampler (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  tvr_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output tvr_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_we,
   input  logic [tvr_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [tvr_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   tvr_pkg::ctl_cmd_type    cmd;
   tvr_pkg::ctl_status_type status;

   tvr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tvr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

   // a pending result is never overwritten
   `AST_IMP(a_no_overwrite, clock, reset, cmd.load_rsp, !(rsp_valid && !rsp_ready))
   // the block is busy right after taking a transaction
   `AST_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // divider, memory, multiplier and output load never overlap
   `AST_IMP(a_one_unit, clock, reset, 1'b1,
            $onehot0({cmd.div_step, cmd.rd_en, cmd.mul_en, cmd.load_rsp}))

endmodule

// ===== tb/sv/tb_trilinear_volume_resampler.sv =====
// self-checking testbench for the trilinear volume resampler
// depends on tvr_pkg and trilinear_volume_resampler; predicts most samples in place
`timescale 1ns / 1ps

module tb_trilinear_volume_resampler;
   import tvr_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] REG_SPARE = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] REG_LAST  = 3'd7;

   typedef struct packed {
      req_type r;
      logic    typed;
      rsp_type e;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   int      voxels[STORE_DEPTH];
   int      dim_in[3];
   int      dim_out[3];
   rsp_type pending_samples[$];
   int      errors = 0;
   bit      long_hold = 0;
   bit      tx_eager = 0;
   int      first_item = 1;

   trilinear_volume_resampler dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------- predictor ----------------
   function automatic void axis_source(input int o, input int n_in, input int n_out,
                                       output int lo, output int hi, output longint t);
      longint num, s, smax;
      num  = longint'((2 * o + 1) * n_in) << 15;
      s    = num / n_out - 32768;
      smax = longint'(n_in - 1) << 16;
      if (s < 0) s = 0;
      if (s > smax) s = smax;
      lo = int'(s >> 16);
      t  = s & 64'hFFFF;
      hi = (lo + 1 < n_in) ? lo + 1 : n_in - 1;
   endfunction

   function automatic longint mix(input longint a, input longint b, input longint t);
      return a * (65536 - t) + b * t;
   endfunction

   function automatic longint vox(input int x, input int y, input int z);
      return voxels[(z * MAX_IN_DIM + y) * MAX_IN_DIM + x];
   endfunction

   function automatic rsp_type interpolate(input req_type r);
      rsp_type res;
      int      x0, x1, y0, y1, z0, z1;
      longint  tx, ty, tz, c00, c10, c01, c11, c0, c1, v;
      res = '0;
      if (r.pos_x >= dim_out[0] || r.pos_y >= dim_out[1] || r.pos_z >= dim_out[2]) begin
         res.out_of_range = 1'b1;
         return res;
      end
      axis_source(r.pos_x, dim_in[0], dim_out[0], x0, x1, tx);
      axis_source(r.pos_y, dim_in[1], dim_out[1], y0, y1, ty);
      axis_source(r.pos_z, dim_in[2], dim_out[2], z0, z1, tz);
      c00 = mix(vox(x0, y0, z0), vox(x1, y0, z0), tx);
      c10 = mix(vox(x0, y1, z0), vox(x1, y1, z0), tx);
      c01 = mix(vox(x0, y0, z1), vox(x1, y0, z1), tx);
      c11 = mix(vox(x0, y1, z1), vox(x1, y1, z1), tx);
      c0  = (mix(c00, c10, ty) + 32768) >>> 16;
      c1  = (mix(c01, c11, ty) + 32768) >>> 16;
      v   = (mix(c0, c1, tz) + (64'sd1 <<< 31)) >>> 32;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      res.sample_value = VALUE_BITS'(v);
      return res;
   endfunction

   // ---------------- stimulus ----------------
   task automatic issue(input req_type r, input logic typed = 1'b0, input rsp_type e = '0);
      int gap;
      gap = tx_eager ? 0 : $urandom_range(0, 7);
      if (first_item) gap = 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      first_item = 0;
      do @(posedge clock); while (!req_ready);
      if (r.command == CMD_WRITE) begin
         if (r.pos_x < dim_in[0] && r.pos_y < dim_in[1] && r.pos_z < dim_in[2])
            voxels[(r.pos_z * MAX_IN_DIM + r.pos_y) * MAX_IN_DIM + r.pos_x] =
               int'(r.voxel_value);
      end else begin
         pending_samples.push_back(typed ? e : interpolate(r));
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      first_item = 1;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      int m;
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx <= REG_IN_DEPTH) begin
         m = val[IN_DIM_BITS-1:0];
         dim_in[idx] = (m == 0) ? 1 : (m > MAX_IN_DIM) ? MAX_IN_DIM : m;
      end else if (idx <= REG_OUT_DEPTH) begin
         m = val[OUT_DIM_BITS-1:0];
         dim_out[idx - REG_OUT_WIDTH] = (m == 0) ? 1 : (m > MAX_OUT_DIM) ? MAX_OUT_DIM : m;
      end
   endtask

   task automatic configure(input int iw, ih, id, ow, oh, od);
      csr_write(REG_IN_WIDTH, CSR_DATA_BITS'(iw));
      csr_write(REG_IN_HEIGHT, CSR_DATA_BITS'(ih));
      csr_write(REG_IN_DEPTH, CSR_DATA_BITS'(id));
      csr_write(REG_OUT_WIDTH, CSR_DATA_BITS'(ow));
      csr_write(REG_OUT_HEIGHT, CSR_DATA_BITS'(oh));
      csr_write(REG_OUT_DEPTH, CSR_DATA_BITS'(od));
   endtask

   // every voxel of the input grid is written before any sample reads it
   task automatic fill_volume();
      req_type r;
      for (int z = 0; z < dim_in[2]; z++)
         for (int y = 0; y < dim_in[1]; y++)
            for (int x = 0; x < dim_in[0]; x++) begin
               r = '{CMD_WRITE, 8'(x), 8'(y), 8'(z), 16'($urandom)};
               issue(r);
            end
   endtask

   function automatic req_type random_item();
      req_type r;
      int      pick, ax;
      pick = $urandom_range(0, 99);
      r = '{CMD_SAMPLE, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom)};
      if (pick < 20) begin
         r.command = CMD_WRITE;
         r.pos_x = 8'($urandom_range(0, dim_in[0] - 1));
         r.pos_y = 8'($urandom_range(0, dim_in[1] - 1));
         r.pos_z = 8'($urandom_range(0, dim_in[2] - 1));
      end else if (pick < 27) begin
         r.command = CMD_WRITE;  // mostly off-grid, dropped by the block
      end else begin
         r.pos_x = 8'($urandom_range(0, dim_out[0] - 1));
         r.pos_y = 8'($urandom_range(0, dim_out[1] - 1));
         r.pos_z = 8'($urandom_range(0, dim_out[2] - 1));
         if (pick < 37) begin
            ax = $urandom_range(0, 2);
            if (dim_out[ax] < 256) begin
               if (ax == 0) r.pos_x = 8'($urandom_range(dim_out[0], 255));
               if (ax == 1) r.pos_y = 8'($urandom_range(dim_out[1], 255));
               if (ax == 2) r.pos_z = 8'($urandom_range(dim_out[2], 255));
            end
         end
      end
      return r;
   endfunction

   task automatic run_phase(input int iw, ih, id, ow, oh, od, input int count);
      drain();
      configure(iw, ih, id, ow, oh, od);
      tx_eager = $urandom_range(0, 1);
      fill_volume();
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) tx_eager = $urandom_range(0, 1);
         issue(random_item());
      end
   endtask

   // ---------------- response side ----------------
   initial begin
      int gap, n;
      bit rx_eager;
      rx_eager = 0;
      n = 0;
      forever begin
         if (n % 32 == 0) rx_eager = $urandom_range(0, 1);
         n++;
         gap = rx_eager ? 0 : $urandom_range(0, 7);
         if (long_hold) gap = 400;
         if (gap > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
            long_hold = 0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_samples.size() == 0) begin
            $error("unexpected sample transaction: value %0d oor %0b",
                   rsp_data.sample_value, rsp_data.out_of_range);
            errors++;
         end else begin
            want = pending_samples.pop_front();
            if (rsp_data.sample_value !== want.sample_value) begin
               $error("sample_value: expected %0d, got %0d",
                      want.sample_value, rsp_data.sample_value);
               errors++;
            end
            if (rsp_data.out_of_range !== want.out_of_range) begin
               $error("out_of_range: expected %0b, got %0b",
                      want.out_of_range, rsp_data.out_of_range);
               errors++;
            end
         end
      end
   end

   // ---------------- sequence ----------------
   initial begin
      dir_row_type rows[$];
      int          wait_cycles;
      dim_in  = '{1, 1, 1};
      dim_out = '{1, 1, 1};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset sizes: a single voxel and a single output point
      rows = '{
         '{'{CMD_WRITE, 8'd0, 8'd0, 8'd0, 16'sh7FFF}, 1'b0, '0},
         '{'{CMD_SAMPLE, 8'd0, 8'd0, 8'd0, 16'sh0000}, 1'b1, '{16'sh7FFF, 1'b0}},
         '{'{CMD_WRITE, 8'd0, 8'd0, 8'd0, 16'sh8000}, 1'b0, '0},
         '{'{CMD_SAMPLE, 8'd0, 8'd0, 8'd0, 16'shFFFF}, 1'b1, '{16'sh8000, 1'b0}},
         '{'{CMD_WRITE, 8'd255, 8'd255, 8'd255, 16'sh0001}, 1'b0, '0},
         '{'{CMD_SAMPLE, 8'd0, 8'd0, 8'd0, 16'sh0000}, 1'b1, '{16'sh8000, 1'b0}},
         '{'{CMD_SAMPLE, 8'd1, 8'd0, 8'd0, 16'sh0000}, 1'b1, '{16'sh0000, 1'b1}},
         '{'{CMD_SAMPLE, 8'd0, 8'd255, 8'd0, 16'sh0000}, 1'b1, '{16'sh0000, 1'b1}},
         '{'{CMD_SAMPLE, 8'd0, 8'd0, 8'd255, 16'sh0000}, 1'b1, '{16'sh0000, 1'b1}},
         '{'{CMD_SAMPLE, 8'd255, 8'd255, 8'd255, 16'sh7FFF}, 1'b1, '{16'sh0000, 1'b1}},
         '{'{CMD_WRITE, 8'd0, 8'd0, 8'd0, 16'sh5555}, 1'b0, '0},
         '{'{CMD_SAMPLE, 8'd0, 8'd0, 8'd0, 16'shAAAA}, 1'b1, '{16'sh5555, 1'b0}},
         '{'{CMD_WRITE, 8'd1, 8'd0, 8'd0, 16'sh1234}, 1'b0, '0},
         '{'{CMD_SAMPLE, 8'd0, 8'd0, 8'd0, 16'sh0000}, 1'b1, '{16'sh5555, 1'b0}}
      };
      foreach (rows[i]) issue(rows[i].r, rows[i].typed, rows[i].e);

      // unused indexes must leave the sizes alone
      drain();
      csr_write(REG_SPARE, 9'h1FF);
      csr_write(REG_LAST, 9'h000);
      issue('{CMD_SAMPLE, 8'd0, 8'd0, 8'd0, 16'sh0000}, 1'b1, '{16'sh5555, 1'b0});

      // small grids with upsampling, extremes along each axis, saturating writes
      drain();
      configure(2, 2, 2, 5, 3, 7);
      fill_volume();
      long_hold = 1;  // output side stalls while requests keep coming
      for (int i = 0; i < 110; i++) issue(random_item());
      run_phase(64, 1, 1, 256, 1, 3, 80);
      run_phase(1, 64, 1, 0, 511, 2, 80);
      run_phase(1, 1, 127, 3, 2, 300, 80);
      run_phase(1, 1, 130, 1, 1, 1, 20);
      run_phase(4, 3, 3, 8, 9, 6, 55);
      // let the block run dry mid-phase
      @(negedge clock);
      req_valid <= 1'b0;
      first_item = 1;
      while (pending_samples.size() != 0) @(posedge clock);
      for (int i = 0; i < 55; i++) issue(random_item());
      for (int p = 0; p < 2; p++)
         run_phase($urandom_range(1, 5), $urandom_range(1, 5), $urandom_range(1, 5),
                   $urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16), 110);

      @(negedge clock);
      req_valid <= 1'b0;
      wait_cycles = 0;
      while (pending_samples.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (pending_samples.size() != 0) begin
         $error("%0d sample transactions never arrived", pending_samples.size());
         errors++;
      end
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
